/* sv/pimrp_pkg.sv */
// shared widths, types and control struct for the point-in-mesh ray parity block
package pimrp_pkg;

   localparam int COORD_W = 32;              // vertex and point coordinate width
   localparam int DIFF_W  = COORD_W + 1;     // edge and tvec components
   localparam int OPND_W  = DIFF_W + 2;      // multiplier operand width
   localparam int PROD_W  = 2 * OPND_W;      // full product width
   localparam int WIDE_W  = 2 * DIFF_W + 1;  // det, u and qvec components
   localparam int SPLIT   = WIDE_W / 2;      // low slice of a qvec component
   localparam int ACC_W   = WIDE_W + DIFF_W + 4;
   localparam int CNT_W   = 17;
   localparam int IDX_W   = 2;

   typedef logic signed [DIFF_W-1:0] diff_type;
   typedef logic signed [OPND_W-1:0] opnd_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [WIDE_W-1:0] wide_type;
   typedef logic signed [ACC_W-1:0]  acc_type;

   // per-multiply control into the shared multiply-accumulate unit
   typedef struct packed {
      logic valid;
      logic clear;  // start a fresh sum
      logic sub;    // subtract the product
      logic shift;  // product belongs to the upper slice of a qvec component
   } mac_ctl_type;

   localparam logic [IDX_W-1:0] REG_POINT_X = 2'd0;
   localparam logic [IDX_W-1:0] REG_POINT_Y = 2'd1;
   localparam logic [IDX_W-1:0] REG_POINT_Z = 2'd2;

endpackage

/* sv/pimrp_mac.sv */
// shared signed multiplier with registered product and wide accumulator
module pimrp_mac (
   input  logic                  clock,
   input  logic                  reset,
   input  pimrp_pkg::mac_ctl_type ctl,
   input  pimrp_pkg::opnd_type   op_a,
   input  pimrp_pkg::opnd_type   op_b,
   output pimrp_pkg::acc_type    acc_sum,
   output pimrp_pkg::acc_type    acc_value
);

   pimrp_pkg::prod_type    prod_ff;
   pimrp_pkg::mac_ctl_type pctl_ff;
   pimrp_pkg::acc_type     acc_ff;
   pimrp_pkg::acc_type     prod_ext;
   pimrp_pkg::acc_type     term;
   pimrp_pkg::acc_type     base;

   always_comb begin
      prod_ext = {{(pimrp_pkg::ACC_W - pimrp_pkg::PROD_W){prod_ff[pimrp_pkg::PROD_W-1]}},
                  prod_ff};
      term     = pctl_ff.shift ? (prod_ext <<< pimrp_pkg::SPLIT) : prod_ext;
      base     = pctl_ff.clear ? '0 : acc_ff;
      acc_sum  = pctl_ff.sub ? (base - term) : (base + term);
   end

   assign acc_value = acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pctl_ff <= '0;
      end else begin
         pctl_ff <= ctl;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
      if (pctl_ff.valid) begin
         acc_ff <= acc_sum;
      end
   end

endmodule

/* sv/pimrp_test.sv */
// sign-normalized barycentric and distance checks for one triangle
module pimrp_test (
   input  pimrp_pkg::wide_type det,
   input  pimrp_pkg::wide_type u,
   input  pimrp_pkg::wide_type v,
   input  pimrp_pkg::acc_type  t,
   output logic                hit
);

   localparam int CMP_W = pimrp_pkg::WIDE_W + 2;

   logic signed [CMP_W-1:0] de;
   logic signed [CMP_W-1:0] ue;
   logic signed [CMP_W-1:0] ve;
   logic signed [CMP_W-1:0] uv;
   logic signed [CMP_W-1:0] d_minus_u;
   logic signed [CMP_W-1:0] u_minus_d;
   logic signed [CMP_W-1:0] d_minus_uv;
   logic signed [CMP_W-1:0] uv_minus_d;
   logic                    det_neg;
   logic                    pos_ok;
   logic                    neg_ok;

   always_comb begin
      de = {{2{det[pimrp_pkg::WIDE_W-1]}}, det};
      ue = {{2{u[pimrp_pkg::WIDE_W-1]}}, u};
      ve = {{2{v[pimrp_pkg::WIDE_W-1]}}, v};
      uv         = ue + ve;
      d_minus_u  = de - ue;
      u_minus_d  = ue - de;
      d_minus_uv = de - uv;
      uv_minus_d = uv - de;
      det_neg    = det[pimrp_pkg::WIDE_W-1];
      // det > 0: 0 <= u <= det, v >= 0, u + v <= det, t > 0
      pos_ok = !u[pimrp_pkg::WIDE_W-1] && !d_minus_u[CMP_W-1] &&
               !v[pimrp_pkg::WIDE_W-1] && !d_minus_uv[CMP_W-1] &&
               !t[pimrp_pkg::ACC_W-1] && (|t);
      // det < 0: same tests with every sign flipped
      neg_ok = (u[pimrp_pkg::WIDE_W-1] || (u == '0)) && !u_minus_d[CMP_W-1] &&
               (v[pimrp_pkg::WIDE_W-1] || (v == '0)) && !uv_minus_d[CMP_W-1] &&
               t[pimrp_pkg::ACC_W-1];
      hit = (|det) && (det_neg ? neg_ok : pos_ok);
   end

endmodule

/* sv/point_in_mesh_ray_parity.sv */
// top level: triangle sequencer around one shared multiply-accumulate unit
// a new triangle is accepted only in idle, once the previous result has been loaded for output
// each triangle runs 16 multiply steps through the one multiplier, then accumulate drain,
//   hit check and result load; the result load waits while the response register is full
// reset: synchronous, clears the point registers, the hit count and all handshakes
module point_in_mesh_ray_parity (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [287:0]                req_tdata,  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
   input  logic                        req_tlast,  // last_triangle
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [23:0]                 rsp_tdata,  // hit, crossings[16:0], inside_res, zero pad
   output logic                        rsp_tlast,  // done_res
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [pimrp_pkg::IDX_W-1:0] csr_index,
   input  logic [31:0]                 csr_data
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MUL   = 3'd1;
   localparam logic [2:0] ST_DRAIN = 3'd2;
   localparam logic [2:0] ST_CHK   = 3'd3;
   localparam logic [2:0] ST_OUT   = 3'd4;

   localparam logic [3:0] S_DET0  = 4'd0;
   localparam logic [3:0] S_DET1  = 4'd1;
   localparam logic [3:0] S_U0    = 4'd2;
   localparam logic [3:0] S_U1    = 4'd3;
   localparam logic [3:0] S_QX0   = 4'd4;
   localparam logic [3:0] S_QX1   = 4'd5;
   localparam logic [3:0] S_QY0   = 4'd6;
   localparam logic [3:0] S_QY1   = 4'd7;
   localparam logic [3:0] S_QZ0   = 4'd8;
   localparam logic [3:0] S_QZ1   = 4'd9;
   localparam logic [3:0] S_TX_LO = 4'd10;
   localparam logic [3:0] S_TX_HI = 4'd11;
   localparam logic [3:0] S_TY_LO = 4'd12;
   localparam logic [3:0] S_TY_HI = 4'd13;
   localparam logic [3:0] S_TZ_LO = 4'd14;
   localparam logic [3:0] S_TZ_HI = 4'd15;

   localparam int CW = pimrp_pkg::COORD_W;

   logic [2:0] state_ff, state_in;
   logic [3:0] step_ff, step_in;
   logic [3:0] acc_step_ff;
   logic       acc_vld_ff;

   logic signed [CW-1:0] point_x_ff, point_y_ff, point_z_ff;
   logic [pimrp_pkg::CNT_W-1:0] count_ff;
   logic [pimrp_pkg::CNT_W-1:0] count_in;

   pimrp_pkg::diff_type e1x_ff, e1y_ff, e1z_ff, e2x_ff, e2y_ff, e2z_ff, tx_ff, ty_ff, tz_ff;
   pimrp_pkg::wide_type det_ff, u_ff, qx_ff, qy_ff, qz_ff;
   logic last_ff;
   logic hit_ff;
   logic hit_chk;

   logic                        rsp_valid_ff;
   logic                        rsp_hit_ff;
   logic [pimrp_pkg::CNT_W-1:0] rsp_cnt_ff;
   logic                        rsp_last_ff;

   logic accept;
   logic load_rsp;

   pimrp_pkg::mac_ctl_type ctl;
   pimrp_pkg::opnd_type    op_a, op_b;
   pimrp_pkg::acc_type     acc_sum, acc_value;

   logic signed [CW-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;

   function automatic pimrp_pkg::opnd_type ext_d(input pimrp_pkg::diff_type d);
      return {{(pimrp_pkg::OPND_W - pimrp_pkg::DIFF_W){d[pimrp_pkg::DIFF_W-1]}}, d};
   endfunction

   function automatic pimrp_pkg::opnd_type lo_q(input pimrp_pkg::wide_type q);
      return {{(pimrp_pkg::OPND_W - pimrp_pkg::SPLIT){1'b0}}, q[pimrp_pkg::SPLIT-1:0]};
   endfunction

   function automatic pimrp_pkg::opnd_type hi_q(input pimrp_pkg::wide_type q);
      return {{(pimrp_pkg::OPND_W - pimrp_pkg::WIDE_W + pimrp_pkg::SPLIT)
               {q[pimrp_pkg::WIDE_W-1]}}, q[pimrp_pkg::WIDE_W-1:pimrp_pkg::SPLIT]};
   endfunction

   function automatic pimrp_pkg::diff_type sub_d(input logic signed [CW-1:0] x,
                                                 input logic signed [CW-1:0] y);
      return {x[CW-1], x} - {y[CW-1], y};
   endfunction

   assign ax = req_tdata[0*CW +: CW];
   assign ay = req_tdata[1*CW +: CW];
   assign az = req_tdata[2*CW +: CW];
   assign bx = req_tdata[3*CW +: CW];
   assign by = req_tdata[4*CW +: CW];
   assign bz = req_tdata[5*CW +: CW];
   assign cx = req_tdata[6*CW +: CW];
   assign cy = req_tdata[7*CW +: CW];
   assign cz = req_tdata[8*CW +: CW];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign load_rsp   = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_tready);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {5'b0, rsp_cnt_ff[0], rsp_cnt_ff, rsp_hit_ff};

   // operand select and accumulate control for each multiply step
   always_comb begin
      ctl       = '0;
      ctl.valid = (state_ff == ST_MUL);
      op_a      = ext_d(e1z_ff);
      op_b      = ext_d(e2y_ff);
      unique case (step_ff)
         S_DET0: begin
            op_a = ext_d(e1z_ff); op_b = ext_d(e2y_ff); ctl.clear = 1'b1;
         end
         S_DET1: begin
            op_a = ext_d(e1y_ff); op_b = ext_d(e2z_ff); ctl.sub = 1'b1;
         end
         S_U0: begin
            op_a = ext_d(tz_ff); op_b = ext_d(e2y_ff); ctl.clear = 1'b1;
         end
         S_U1: begin
            op_a = ext_d(ty_ff); op_b = ext_d(e2z_ff); ctl.sub = 1'b1;
         end
         S_QX0: begin
            op_a = ext_d(ty_ff); op_b = ext_d(e1z_ff); ctl.clear = 1'b1;
         end
         S_QX1: begin
            op_a = ext_d(tz_ff); op_b = ext_d(e1y_ff); ctl.sub = 1'b1;
         end
         S_QY0: begin
            op_a = ext_d(tz_ff); op_b = ext_d(e1x_ff); ctl.clear = 1'b1;
         end
         S_QY1: begin
            op_a = ext_d(tx_ff); op_b = ext_d(e1z_ff); ctl.sub = 1'b1;
         end
         S_QZ0: begin
            op_a = ext_d(tx_ff); op_b = ext_d(e1y_ff); ctl.clear = 1'b1;
         end
         S_QZ1: begin
            op_a = ext_d(ty_ff); op_b = ext_d(e1x_ff); ctl.sub = 1'b1;
         end
         S_TX_LO: begin
            op_a = ext_d(e2x_ff); op_b = lo_q(qx_ff); ctl.clear = 1'b1;
         end
         S_TX_HI: begin
            op_a = ext_d(e2x_ff); op_b = hi_q(qx_ff); ctl.shift = 1'b1;
         end
         S_TY_LO: begin
            op_a = ext_d(e2y_ff); op_b = lo_q(qy_ff);
         end
         S_TY_HI: begin
            op_a = ext_d(e2y_ff); op_b = hi_q(qy_ff); ctl.shift = 1'b1;
         end
         S_TZ_LO: begin
            op_a = ext_d(e2z_ff); op_b = lo_q(qz_ff);
         end
         S_TZ_HI: begin
            op_a = ext_d(e2z_ff); op_b = hi_q(qz_ff); ctl.shift = 1'b1;
         end
      endcase
   end

   pimrp_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .op_a      (op_a),
      .op_b      (op_b),
      .acc_sum   (acc_sum),
      .acc_value (acc_value)
   );

   pimrp_test u_test (
      .det (det_ff),
      .u   (u_ff),
      .v   (qx_ff),
      .t   (acc_value),
      .hit (hit_chk)
   );

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      count_in = count_ff + {{(pimrp_pkg::CNT_W-1){1'b0}}, hit_ff};
      unique case (state_ff)
         ST_IDLE: begin
            step_in = S_DET0;
            if (accept) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            step_in = step_ff + 4'd1;
            if (step_ff == S_TZ_HI) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_CHK;
         ST_CHK:   state_in = ST_OUT;
         ST_OUT: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= S_DET0;
         acc_vld_ff   <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         point_x_ff   <= '0;
         point_y_ff   <= '0;
         point_z_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         step_ff    <= step_in;
         acc_vld_ff <= (state_ff == ST_MUL);
         if (load_rsp) begin
            count_ff     <= last_ff ? '0 : count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid) begin
            unique case (csr_index)
               pimrp_pkg::REG_POINT_X: point_x_ff <= csr_data;
               pimrp_pkg::REG_POINT_Y: point_y_ff <= csr_data;
               pimrp_pkg::REG_POINT_Z: point_z_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_step_ff <= step_ff;
      if (accept) begin
         e1x_ff  <= sub_d(bx, ax);
         e1y_ff  <= sub_d(by, ay);
         e1z_ff  <= sub_d(bz, az);
         e2x_ff  <= sub_d(cx, ax);
         e2y_ff  <= sub_d(cy, ay);
         e2z_ff  <= sub_d(cz, az);
         tx_ff   <= sub_d(point_x_ff, ax);
         ty_ff   <= sub_d(point_y_ff, ay);
         tz_ff   <= sub_d(point_z_ff, az);
         last_ff <= req_tlast;
      end
      // capture each finished sum as its second product lands
      if (acc_vld_ff) begin
         unique case (acc_step_ff)
            S_DET1:  det_ff <= acc_sum[pimrp_pkg::WIDE_W-1:0];
            S_U1:    u_ff   <= acc_sum[pimrp_pkg::WIDE_W-1:0];
            S_QX1:   qx_ff  <= acc_sum[pimrp_pkg::WIDE_W-1:0];
            S_QY1:   qy_ff  <= acc_sum[pimrp_pkg::WIDE_W-1:0];
            S_QZ1:   qz_ff  <= acc_sum[pimrp_pkg::WIDE_W-1:0];
            default: ;
         endcase
      end
      if (state_ff == ST_CHK) begin
         hit_ff <= hit_chk;
      end
      if (load_rsp) begin
         rsp_hit_ff  <= hit_ff;
         rsp_cnt_ff  <= count_in;
         rsp_last_ff <= last_ff;
      end
   end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// self-checking testbench for point_in_mesh_ray_parity with a ray-cast predictor
module tb_top;

   localparam logic [pimrp_pkg::IDX_W-1:0] REG_UNMAPPED = 2'd3;
   localparam logic signed [31:0] COORD_MAX    = 32'sh7fff_ffff;
   localparam logic signed [31:0] COORD_MIN    = 32'sh8000_0000;
   localparam int                 ONE          = 65536;  // 1.0 in Q16.16
   localparam int                 HOLD_CYCLES  = 600;
   localparam int                 MAX_PRINT    = 100;

   typedef enum int {SHAPE_NOISE, SHAPE_GRID, SHAPE_WIDE, SHAPE_FLAT} shape_type;

   typedef struct {
      logic signed [31:0] crd [9];  // a_x a_y a_z b_x b_y b_z c_x c_y c_z
      logic               last;
   } facet_type;

   typedef struct {
      logic        hit;
      logic [16:0] crossings;
      logic        parity;
      logic        done;
   } crossing_type;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [287:0]         req_tdata;  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
   logic                 req_tlast;  // last_triangle
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [23:0]          rsp_tdata;  // hit, crossings[16:0], inside_res, zero pad
   logic                 rsp_tlast;  // done_res
   logic                 csr_valid;
   logic                 csr_ready;
   logic [pimrp_pkg::IDX_W-1:0] csr_index;
   logic [31:0]          csr_data;

   // predictor state
   logic signed [31:0]   query_x;
   logic signed [31:0]   query_y;
   logic signed [31:0]   query_z;
   logic [16:0]          hit_tally;
   crossing_type         crossing_q[$];

   int                   mismatch_count;
   int                   burst_left;
   bit                   gaps_on;
   bit                   rx_pattern_on;
   bit                   hold_off_req;

   point_in_mesh_ray_parity dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("Regression FAIL");
      $finish;
   end

   task automatic report_mismatch(input string what);
      if (mismatch_count < MAX_PRINT)
         $display("[%0t] mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   // exact division-free ray/triangle test, ray from the query point along +x
   function automatic logic ray_crosses(input facet_type f);
      logic signed [127:0] ax, ay, az, e1x, e1y, e1z, e2x, e2y, e2z, tx, ty, tz;
      logic signed [127:0] det, u, v, t, qx, qy, qz;
      ax = f.crd[0];
      ay = f.crd[1];
      az = f.crd[2];
      e1x = f.crd[3];
      e1x -= ax;
      e1y = f.crd[4];
      e1y -= ay;
      e1z = f.crd[5];
      e1z -= az;
      e2x = f.crd[6];
      e2x -= ax;
      e2y = f.crd[7];
      e2y -= ay;
      e2z = f.crd[8];
      e2z -= az;
      tx = query_x;
      tx -= ax;
      ty = query_y;
      ty -= ay;
      tz = query_z;
      tz -= az;
      det = e1z * e2y - e1y * e2z;
      if (det == 0)
         return 1'b0;
      u = tz * e2y - ty * e2z;
      qx = ty * e1z - tz * e1y;
      qy = tz * e1x - tx * e1z;
      qz = tx * e1y - ty * e1x;
      v = qx;
      t = e2x * qx + e2y * qy + e2z * qz;
      if (det < 0) begin
         det = -det;
         u = -u;
         v = -v;
         t = -t;
      end
      return (u >= 0) && (u <= det) && (v >= 0) && (u + v <= det) && (t > 0);
   endfunction

   function automatic void predict_crossing(input facet_type f);
      crossing_type r;
      r.hit = ray_crosses(f);
      r.crossings = hit_tally + {16'd0, r.hit};  // wraps at 17 bits
      r.parity = r.crossings[0];
      r.done = f.last;
      hit_tally = f.last ? '0 : r.crossings;
      crossing_q = {crossing_q, r};
   endfunction

   function automatic facet_type facet_u(input int ax, ay, az, bx, by, bz, cx, cy, cz,
                                         input bit last);
      facet_type f;
      int        u [9];
      int        i;
      u = '{ax, ay, az, bx, by, bz, cx, cy, cz};
      for (i = 0; i < 9; i++)
         f.crd[i] = u[i] * ONE;
      f.last = last;
      return f;
   endfunction

   // triangles placed around the query point (noise shapes apart) so that a fair share cross the ray
   function automatic facet_type random_facet(input shape_type shape);
      facet_type          f;
      int                 i, k, unit, span;
      logic signed [31:0] base [3];
      base[0] = query_x;
      base[1] = query_y;
      base[2] = query_z;
      unit = 1 << $urandom_range(0, 26);
      span = $urandom_range(4, 30);
      for (i = 0; i < 9; i++) begin
         case (shape)
            SHAPE_NOISE: f.crd[i] = $urandom;
            SHAPE_WIDE:  f.crd[i] = base[i % 3] + ($urandom & ((1 << span) - 1))
                                    - (1 << (span - 1));
            default: begin
               k = $urandom_range(0, 8);
               k = k - 4;
               f.crd[i] = base[i % 3] + k * unit;
            end
         endcase
      end
      if (shape == SHAPE_FLAT) begin
         if ($urandom_range(0, 1))
            for (i = 0; i < 3; i++)
               f.crd[3 + i] = f.crd[i];
         else
            for (i = 0; i < 3; i++)
               f.crd[6 + i] = f.crd[i] + 2 * (f.crd[3 + i] - f.crd[i]);
      end
      f.last = 1'b0;
      return f;
   endfunction

   task automatic send_facet(input facet_type f);
      logic [287:0] packed_crd;
      int           gap;
      int           i;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if (gaps_on)
            gap = $urandom_range(1, 24);
      end
      burst_left--;
      for (i = 0; i < 9; i++)
         packed_crd[32 * i +: 32] = f.crd[i];
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= packed_crd;
      req_tlast  <= f.last;
      do @(posedge clock); while (!req_tready);
      predict_crossing(f);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (crossing_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_point_reg(input logic [pimrp_pkg::IDX_W-1:0] idx,
                                  input logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         pimrp_pkg::REG_POINT_X: query_x = value;
         pimrp_pkg::REG_POINT_Y: query_y = value;
         pimrp_pkg::REG_POINT_Z: query_z = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_point(input logic [31:0] px, py, pz);
      write_point_reg(pimrp_pkg::REG_POINT_X, px);
      write_point_reg(pimrp_pkg::REG_POINT_Y, py);
      write_point_reg(pimrp_pkg::REG_POINT_Z, pz);
   endtask

   task automatic run_meshes(input int n_items);
      int        sent, len, j, pick;
      facet_type f;
      shape_type shape;
      sent = 0;
      while (sent < n_items) begin
         len = $urandom_range(1, 10);
         for (j = 0; j < len; j++) begin
            pick = $urandom_range(0, 99);
            shape = pick < 10 ? SHAPE_NOISE : pick < 65 ? SHAPE_GRID :
                    pick < 90 ? SHAPE_WIDE : SHAPE_FLAT;
            f = random_facet(shape);
            // noise triangles may also cut a mesh short
            f.last = (j == len - 1) || (shape == SHAPE_NOISE && $urandom_range(0, 3) == 0);
            send_facet(f);
         end
         sent += len;
      end
      drain_results();
   endtask

   // query point at its reset value: vertices, edges, windings, degenerate and extreme triangles
   task automatic test_edge_cases();
      facet_type f;
      send_facet(facet_u(5, 0, 0, 5, 4, 0, 5, 0, 4, 1'b0));       // ray through vertex a
      send_facet(facet_u(5, -4, 0, 5, 0, 0, 5, -4, 4, 1'b0));     // through vertex b
      send_facet(facet_u(5, -4, -4, 5, 4, -4, 5, 0, 0, 1'b0));    // through vertex c
      send_facet(facet_u(5, -2, 0, 5, 2, 0, 5, 0, 3, 1'b0));      // on edge ab
      send_facet(facet_u(5, 0, -2, 5, 3, 0, 5, 0, 2, 1'b0));      // on edge ac
      send_facet(facet_u(5, -2, -2, 5, 2, -2, 5, -2, 2, 1'b0));   // on edge bc
      send_facet(facet_u(7, -1, -1, 7, -1, 3, 7, 3, -1, 1'b0));   // positive det
      send_facet(facet_u(0, -1, -1, 0, 3, -1, 0, -1, 3, 1'b0));   // origin on the plane
      send_facet(facet_u(-5, -1, -1, -5, 3, -1, -5, -1, 3, 1'b0)); // plane behind the origin
      send_facet(facet_u(5, -1, -1, 5, 1, 1, 5, 3, 3, 1'b0));     // collinear
      send_facet(facet_u(5, 0, 0, 5, 0, 0, 5, 0, 0, 1'b0));       // single point
      send_facet(facet_u(2, -2, -2, 8, 2, -2, 4, -2, 2, 1'b0));   // tilted plane
      send_facet(facet_u(0, -1, 0, 5, 1, 0, 3, 2, 0, 1'b0));      // ray parallel to plane
      f.crd = '{COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN,
                COORD_MAX, COORD_MIN, COORD_MAX};
      f.last = 1'b0;
      send_facet(f);
      f.crd = '{COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN,
                COORD_MAX, COORD_MAX, COORD_MAX};
      send_facet(f);
      f.crd = '{default: COORD_MAX};
      send_facet(f);
      f.crd = '{default: COORD_MIN};
      f.last = 1'b1;
      send_facet(f);
      drain_results();
   endtask

   task automatic send_tetrahedron();
      send_facet(facet_u(-2, -2, -2, 6, -2, -2, -2, 6, -2, 1'b0));
      send_facet(facet_u(-2, -2, -2, 6, -2, -2, -2, -2, 6, 1'b0));
      send_facet(facet_u(-2, -2, -2, -2, 6, -2, -2, -2, 6, 1'b0));
      send_facet(facet_u(6, -2, -2, -2, 6, -2, -2, -2, 6, 1'b1));
   endtask

   // closed mesh with the point inside, then outside; unmapped index must be ignored
   task automatic test_closed_mesh();
      set_point(32'd0, 32'd0, 32'd0);
      send_tetrahedron();
      drain_results();
      write_point_reg(REG_UNMAPPED, $urandom);
      write_point_reg(pimrp_pkg::REG_POINT_X, 10 * ONE);
      send_tetrahedron();
      drain_results();
   endtask

   task automatic test_point_extremes();
      gaps_on = 1'b1;
      rx_pattern_on = 1'b1;
      set_point(COORD_MAX, COORD_MAX, COORD_MAX);
      run_meshes(130);
      set_point(COORD_MIN, COORD_MIN, COORD_MIN);
      run_meshes(130);
      set_point(COORD_MAX, COORD_MIN, 32'd0);
      run_meshes(90);
   endtask

   task automatic test_random_meshes();
      int phase, k;
      for (phase = 0; phase < 5; phase++) begin
         gaps_on = (phase != 2) && (phase != 4);
         rx_pattern_on = (phase != 3) && (phase != 4);
         if (phase % 2)
            set_point($urandom, $urandom, $urandom);
         else begin
            k = $urandom_range(0, 64);
            write_point_reg(pimrp_pkg::REG_POINT_X, (k - 32) * (ONE / 2));
            k = $urandom_range(0, 64);
            write_point_reg(pimrp_pkg::REG_POINT_Y, (k - 32) * (ONE / 2));
            k = $urandom_range(0, 64);
            write_point_reg(pimrp_pkg::REG_POINT_Z, (k - 32) * (ONE / 2));
         end
         run_meshes(150);
      end
   endtask

   // receiver holds off while the sender keeps offering triangles back to back
   task automatic test_backpressure();
      gaps_on = 1'b0;
      rx_pattern_on = 1'b1;
      hold_off_req = 1'b1;
      run_meshes(60);
   endtask

   initial begin : rsp_side
      int left;
      bit ready_phase;
      rsp_tready = 1'b0;
      left = 0;
      ready_phase = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         if (!rx_pattern_on) begin
            rsp_tready <= 1'b1;
         end else begin
            if (left == 0) begin
               ready_phase = !ready_phase;
               left = ready_phase ? $urandom_range(1, 20) : $urandom_range(1, 8);
            end
            left--;
            rsp_tready <= ready_phase;
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      crossing_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (crossing_q.size() == 0) begin
            report_mismatch("result transaction with no triangle outstanding");
         end else begin
            want = crossing_q.pop_front();
            if (rsp_tdata[0] !== want.hit)
               report_mismatch($sformatf("hit %b, want %b", rsp_tdata[0], want.hit));
            if (rsp_tdata[17:1] !== want.crossings)
               report_mismatch($sformatf("crossings %0d, want %0d",
                                         rsp_tdata[17:1], want.crossings));
            if (rsp_tdata[18] !== want.parity)
               report_mismatch($sformatf("inside %b, want %b", rsp_tdata[18], want.parity));
            if (rsp_tdata[23:19] !== 5'd0)
               report_mismatch($sformatf("pad bits %b, want zero", rsp_tdata[23:19]));
            if (rsp_tlast !== want.done)
               report_mismatch($sformatf("done %b, want %b", rsp_tlast, want.done));
         end
      end
   end

   initial begin
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      reset = 1'b1;
      query_x = '0;
      query_y = '0;
      query_z = '0;
      hit_tally = '0;
      mismatch_count = 0;
      burst_left = 0;
      gaps_on = 1'b1;
      rx_pattern_on = 1'b1;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      test_edge_cases();
      test_closed_mesh();
      test_point_extremes();
      test_random_meshes();
      test_backpressure();
      drain_results();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
